@@ design/vafd_pkg.sv @@
// vafd_pkg: shared types, codes and helper functions for the vertex attribute
// fetch and decode block. no dependencies.
`timescale 1ns / 1ps

package vafd_pkg;

    localparam int BUFFER_BYTES = 4096;
    localparam int BUF_ADDR_W   = $clog2(BUFFER_BYTES);
    localparam int LIMIT_W      = $clog2(BUFFER_BYTES + 1);
    localparam int START_W      = 25;   // 12-bit base plus 16 x 8 product
    localparam int ADDR_W       = 26;   // start plus slot offset plus size

    typedef enum logic [2:0] {
        REG_BASE_OFFSET  = 3'd0,
        REG_STRIDE       = 3'd1,
        REG_ELEMENT_KIND = 3'd2,
        REG_COMP_KIND    = 3'd3,
        REG_NORMALIZE    = 3'd4,
        REG_PRESENT      = 3'd5,
        REG_LENGTH       = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CK_INT8    = 3'd0,
        CK_UINT8   = 3'd1,
        CK_INT16   = 3'd2,
        CK_UINT16  = 3'd3,
        CK_UINT32  = 3'd4,
        CK_FLOAT32 = 3'd5
    } comp_kind_t;

    typedef enum logic [2:0] {
        EK_SCALAR = 3'd0,
        EK_VEC2   = 3'd1,
        EK_VEC3   = 3'd2,
        EK_VEC4   = 3'd3,
        EK_MAT2   = 3'd4,
        EK_MAT3   = 3'd5,
        EK_MAT4   = 3'd6
    } elem_kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_RANGE      = 2'd1,
        ST_NORM_ERROR = 2'd2
    } status_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [31:0] FLOAT_MINUS_ONE = 32'hBF80_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_CHECK,
        S_READ,
        S_CAP,
        S_CONV,
        S_DIV,
        S_OUT
    } fsm_state_t;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [1:0]  kind;
        logic [15:0] mag;
    } div_req_t;

    // bytes per component, kinds above float32 already folded
    function automatic logic [2:0] comp_bytes(input logic [2:0] ck);
        unique case (ck)
            CK_INT8, CK_UINT8:   comp_bytes = 3'd1;
            CK_INT16, CK_UINT16: comp_bytes = 3'd2;
            default:             comp_bytes = 3'd4;
        endcase
    endfunction

    function automatic logic [4:0] comp_count(input logic [2:0] ek);
        unique case (ek)
            EK_SCALAR: comp_count = 5'd1;
            EK_VEC2:   comp_count = 5'd2;
            EK_VEC3:   comp_count = 5'd3;
            EK_VEC4:   comp_count = 5'd4;
            EK_MAT2:   comp_count = 5'd4;
            EK_MAT3:   comp_count = 5'd9;
            default:   comp_count = 5'd16;
        endcase
    endfunction

    // rows per matrix column, 0 for vectors
    function automatic logic [2:0] mat_rows(input logic [2:0] ek);
        unique case (ek)
            EK_MAT2: mat_rows = 3'd2;
            EK_MAT3: mat_rows = 3'd3;
            EK_MAT4, 3'd7: mat_rows = 3'd4;
            default: mat_rows = 3'd0;
        endcase
    endfunction

    // column pitch, padded to whole words
    function automatic logic [4:0] col_pitch(input logic [2:0] rows, input logic [2:0] size);
        logic [4:0] raw;
        raw = 5'(rows) * 5'(size) + 5'd3;
        col_pitch = {raw[4:2], 2'b00};
    endfunction

    function automatic logic [7:0] packed_stride(input logic [2:0] ek, input logic [2:0] size);
        logic [2:0] rows;
        rows = mat_rows(ek);
        if (rows == 3'd0) packed_stride = 8'(comp_count(ek)) * 8'(size);
        else              packed_stride = 8'(rows) * 8'(col_pitch(rows, size));
    endfunction

    function automatic logic [15:0] norm_divisor(input logic [1:0] kind);
        unique case (kind)
            2'd0: norm_divisor = 16'd127;
            2'd1: norm_divisor = 16'd255;
            2'd2: norm_divisor = 16'd32767;
            default: norm_divisor = 16'd65535;
        endcase
    endfunction

    // divisor shifted so bit 15 is set
    function automatic logic [15:0] norm_divisor_top(input logic [1:0] kind);
        unique case (kind)
            2'd0: norm_divisor_top = 16'd65024;
            2'd1: norm_divisor_top = 16'd65280;
            2'd2: norm_divisor_top = 16'd65534;
            default: norm_divisor_top = 16'd65535;
        endcase
    endfunction

    // position of the divisor's leading one
    function automatic logic [3:0] norm_divisor_pos(input logic [1:0] kind);
        unique case (kind)
            2'd0: norm_divisor_pos = 4'd6;
            2'd1: norm_divisor_pos = 4'd7;
            2'd2: norm_divisor_pos = 4'd14;
            default: norm_divisor_pos = 4'd15;
        endcase
    endfunction

endpackage

@@ design/vertex_attribute_fetch_decode_core.sv @@
// vertex_attribute_fetch_decode_core: top level, config registers, element
// sequencer and decode. depends on vafd_pkg, vafd_buffer_ram, vafd_norm_div.
//
//  port group   dir   contents
//  s_*          in    buffer byte writes and element fetches
//  m_*          out   one word per component, tlast on the final one
//  cfg_*        in    register writes, no read-back
//
// a write is taken while idle. a fetch goes through address setup, a range scan
// over the components, then per component buffer reads (one byte per cycle on
// the single read port), a capture, the conversion, the divider for a normalized
// value that is neither zero nor clamped, and the output. one word is handled at
// a time; s_tready is low until the last result is taken. reset is synchronous;
// buffer contents are undefined until written.
`timescale 1ns / 1ps

module vertex_attribute_fetch_decode_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // write_address, write_byte, element_number, zero pad
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // component_value, component_slot, status, zero pad
    output logic        m_tuser,   // value_is_float
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [12:0] cfg_wdata
);

    // configuration
    logic [11:0] base_reg;
    logic [7:0]  stride_reg;
    logic [2:0]  ek_reg;
    logic [2:0]  ck_reg;
    logic        norm_reg;
    logic        present_reg;
    logic [12:0] length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg    <= 12'd0;
            stride_reg  <= 8'd0;
            ek_reg      <= 3'd0;
            ck_reg      <= 3'(vafd_pkg::CK_FLOAT32);
            norm_reg    <= 1'b0;
            present_reg <= 1'b1;
            length_reg  <= 13'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                vafd_pkg::REG_BASE_OFFSET:  base_reg    <= cfg_wdata[11:0];
                vafd_pkg::REG_STRIDE:       stride_reg  <= cfg_wdata[7:0];
                vafd_pkg::REG_ELEMENT_KIND: ek_reg      <= cfg_wdata[2:0];
                vafd_pkg::REG_COMP_KIND:    ck_reg      <= cfg_wdata[2:0];
                vafd_pkg::REG_NORMALIZE:    norm_reg    <= cfg_wdata[0];
                vafd_pkg::REG_PRESENT:      present_reg <= cfg_wdata[0];
                vafd_pkg::REG_LENGTH:       length_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // derived element geometry
    logic [2:0]  ck;
    logic [2:0]  size;
    logic [4:0]  count;
    logic [2:0]  rows;
    logic [4:0]  pitch;
    logic [7:0]  eff_stride;
    logic [12:0] limit;

    always_comb begin
        ck         = (ck_reg > 3'(vafd_pkg::CK_FLOAT32)) ? 3'(vafd_pkg::CK_FLOAT32) : ck_reg;
        size       = vafd_pkg::comp_bytes(ck);
        count      = vafd_pkg::comp_count(ek_reg);
        rows       = vafd_pkg::mat_rows(ek_reg);
        pitch      = vafd_pkg::col_pitch(rows, size);
        eff_stride = (stride_reg != 8'd0) ? stride_reg : vafd_pkg::packed_stride(ek_reg, size);
        limit      = (length_reg > 13'(vafd_pkg::BUFFER_BYTES))
                   ? 13'(vafd_pkg::BUFFER_BYTES) : length_reg;
    end

    vafd_pkg::fsm_state_t state_reg, state_next;

    logic [15:0] num_reg;
    logic [vafd_pkg::START_W-1:0] start_reg;
    logic [3:0]  k_reg;
    logic [5:0]  off_reg, col_reg;
    logic [2:0]  row_reg;
    logic [1:0]  b_reg;
    logic [31:0] raw_reg;
    logic        cap_pend_reg;
    logic [1:0]  cap_sel_reg;

    logic [31:0] out_value_reg;
    logic        out_isf_reg;
    logic [3:0]  out_slot_reg;
    logic [1:0]  out_status_reg;
    logic        out_last_reg;

    logic [vafd_pkg::ADDR_W-1:0] comp_addr, comp_end;
    logic range_fail, k_last, norm_illegal;
    logic [5:0] off_step, col_step;
    logic [2:0] row_step;

    always_comb begin
        comp_addr    = vafd_pkg::ADDR_W'(start_reg) + vafd_pkg::ADDR_W'(off_reg);
        comp_end     = comp_addr + vafd_pkg::ADDR_W'(size);
        range_fail   = comp_end > vafd_pkg::ADDR_W'(limit);
        k_last       = ({1'b0, k_reg} == count - 5'd1);
        norm_illegal = norm_reg && ck >= 3'(vafd_pkg::CK_UINT32);
        // step to the next slot, matrix columns start on padded pitch
        if (rows != 3'd0 && row_reg == rows - 3'd1) begin
            col_step = col_reg + 6'(pitch);
            off_step = col_reg + 6'(pitch);
            row_step = 3'd0;
        end else begin
            col_step = col_reg;
            off_step = off_reg + 6'(size);
            row_step = row_reg + 3'd1;
        end
    end

    // decode of the assembled component
    logic [31:0] raw;
    logic        neg;
    logic [15:0] mag;
    logic        is_signed, small_int, clamp;
    logic [31:0] plain_value;
    logic        plain_isf;

    always_comb begin
        raw       = 32'd0;
        neg       = 1'b0;
        mag       = 16'd0;
        is_signed = 1'b0;
        unique case (size)
            3'd1:    raw = {24'd0, raw_reg[7:0]};
            3'd2:    raw = {16'd0, raw_reg[15:0]};
            default: raw = raw_reg;
        endcase
        unique case (ck)
            vafd_pkg::CK_INT8: begin
                is_signed   = 1'b1;
                neg         = raw[7];
                mag         = neg ? 16'(9'd256 - {1'b0, raw[7:0]}) : {8'd0, raw[7:0]};
                plain_value = {{24{raw[7]}}, raw[7:0]};
            end
            vafd_pkg::CK_INT16: begin
                is_signed   = 1'b1;
                neg         = raw[15];
                mag         = neg ? 16'(17'd65536 - {1'b0, raw[15:0]}) : raw[15:0];
                plain_value = {{16{raw[15]}}, raw[15:0]};
            end
            vafd_pkg::CK_UINT8, vafd_pkg::CK_UINT16: begin
                mag         = raw[15:0];
                plain_value = raw;
            end
            default: plain_value = raw;
        endcase
        small_int = ck <= 3'(vafd_pkg::CK_UINT16);
        clamp     = is_signed && mag > vafd_pkg::norm_divisor(ck[1:0]);
        plain_isf = (ck == 3'(vafd_pkg::CK_FLOAT32));
    end

    // state-driven controls
    logic ram_we, ram_re;
    logic div_done;
    logic [31:0] div_result;
    vafd_pkg::div_req_t div_req;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            vafd_pkg::S_IDLE:
                if (s_tvalid && s_tuser == vafd_pkg::CMD_FETCH) state_next = vafd_pkg::S_ADDR;
            vafd_pkg::S_ADDR:
                state_next = vafd_pkg::S_CHECK;
            vafd_pkg::S_CHECK:
                if (!present_reg)                 state_next = vafd_pkg::S_CONV;
                else if (range_fail || norm_illegal) state_next = vafd_pkg::S_OUT;
                else if (k_last)                  state_next = vafd_pkg::S_READ;
            vafd_pkg::S_READ:
                if ({1'b0, b_reg} == size - 3'd1) state_next = vafd_pkg::S_CAP;
            vafd_pkg::S_CAP:
                state_next = vafd_pkg::S_CONV;
            vafd_pkg::S_CONV:
                if (present_reg && norm_reg && small_int && mag != 16'd0 && !clamp)
                    state_next = vafd_pkg::S_DIV;
                else
                    state_next = vafd_pkg::S_OUT;
            vafd_pkg::S_DIV:
                if (div_done) state_next = vafd_pkg::S_OUT;
            vafd_pkg::S_OUT:
                if (m_tready) begin
                    if (out_last_reg)      state_next = vafd_pkg::S_IDLE;
                    else if (!present_reg) state_next = vafd_pkg::S_CONV;
                    else                   state_next = vafd_pkg::S_READ;
                end
            default: state_next = vafd_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = (state_reg == vafd_pkg::S_IDLE);
        m_tvalid    = (state_reg == vafd_pkg::S_OUT);
        ram_re      = (state_reg == vafd_pkg::S_READ);
        ram_we      = s_tvalid && s_tready && s_tuser == vafd_pkg::CMD_WRITE
                   && {1'b0, s_tdata[11:0]} < 13'(vafd_pkg::BUFFER_BYTES);
        div_req.start = (state_reg == vafd_pkg::S_CONV) && (state_next == vafd_pkg::S_DIV);
        div_req.neg   = neg;
        div_req.kind  = ck[1:0];
        div_req.mag   = mag;
    end

    logic [7:0] ram_rdata;
    logic [vafd_pkg::BUF_ADDR_W-1:0] ram_raddr;
    assign ram_raddr = comp_addr[vafd_pkg::BUF_ADDR_W-1:0] + vafd_pkg::BUF_ADDR_W'(b_reg);

    vafd_buffer_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_tdata[vafd_pkg::BUF_ADDR_W-1:0]),
        .wdata (s_tdata[19:12]),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    vafd_norm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .result  (div_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= vafd_pkg::S_IDLE;
            cap_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_pend_reg <= ram_re;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        cap_sel_reg <= b_reg;
        if (cap_pend_reg) raw_reg[8*cap_sel_reg +: 8] <= ram_rdata;
        unique case (state_reg)
            vafd_pkg::S_IDLE: begin
                num_reg <= s_tdata[35:20];
            end
            vafd_pkg::S_ADDR: begin
                start_reg <= vafd_pkg::START_W'(base_reg)
                           + vafd_pkg::START_W'(num_reg) * vafd_pkg::START_W'(eff_stride);
                k_reg   <= 4'd0;
                off_reg <= 6'd0;
                col_reg <= 6'd0;
                row_reg <= 3'd0;
                b_reg   <= 2'd0;
            end
            vafd_pkg::S_CHECK: begin
                if (present_reg && (range_fail || norm_illegal)) begin
                    out_value_reg  <= 32'd0;
                    out_isf_reg    <= 1'b0;
                    out_slot_reg   <= k_reg;
                    out_status_reg <= range_fail ? vafd_pkg::ST_RANGE : vafd_pkg::ST_NORM_ERROR;
                    out_last_reg   <= 1'b1;
                end else if (k_last || !present_reg) begin
                    k_reg   <= 4'd0;
                    off_reg <= 6'd0;
                    col_reg <= 6'd0;
                    row_reg <= 3'd0;
                end else begin
                    k_reg   <= k_reg + 4'd1;
                    off_reg <= off_step;
                    col_reg <= col_step;
                    row_reg <= row_step;
                end
            end
            vafd_pkg::S_READ: begin
                b_reg <= ({1'b0, b_reg} == size - 3'd1) ? 2'd0 : b_reg + 2'd1;
            end
            vafd_pkg::S_CONV: begin
                out_slot_reg   <= k_reg;
                out_status_reg <= vafd_pkg::ST_OK;
                out_last_reg   <= k_last;
                if (!present_reg) begin
                    out_value_reg <= 32'd0;
                    out_isf_reg   <= plain_isf || (norm_reg && small_int);
                end else if (norm_reg && small_int) begin
                    out_value_reg <= clamp ? vafd_pkg::FLOAT_MINUS_ONE : 32'd0;
                    out_isf_reg   <= 1'b1;
                end else begin
                    out_value_reg <= plain_value;
                    out_isf_reg   <= plain_isf;
                end
            end
            vafd_pkg::S_DIV: begin
                if (div_done) out_value_reg <= div_result;
            end
            vafd_pkg::S_OUT: begin
                if (m_tready) begin
                    k_reg   <= k_reg + 4'd1;
                    off_reg <= off_step;
                    col_reg <= col_step;
                    row_reg <= row_step;
                end
            end
            default: ;
        endcase
    end

    assign m_tdata = {2'd0, out_status_reg, out_slot_reg, out_value_reg};
    assign m_tuser = out_isf_reg;
    assign m_tlast = out_last_reg;

`ifndef NO_ASSERTIONS
    // one word in flight: no new input while a result waits
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    // an error result always closes the element
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[37:36] != vafd_pkg::ST_OK) |-> m_tlast)
        else $error("error result without tlast");

    // buffer reads stay inside the checked range
    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> (comp_end <= vafd_pkg::ADDR_W'(limit)))
        else $error("buffer read beyond length");
`endif

endmodule

@@ design/vafd_buffer_ram.sv @@
// vafd_buffer_ram: byte-wide buffer memory, one write and one registered read
// port. depends on vafd_pkg.
`timescale 1ns / 1ps

module vafd_buffer_ram (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [vafd_pkg::BUF_ADDR_W-1:0] waddr,
    input  logic [7:0]                      wdata,
    input  logic                            re,
    input  logic [vafd_pkg::BUF_ADDR_W-1:0] raddr,
    output logic [7:0]                      rdata
);

    logic [7:0] mem [vafd_pkg::BUFFER_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/vafd_norm_div.sv @@
// vafd_norm_div: magnitude over type maximum to ieee single, round to nearest
// even, four quotient bits per cycle. depends on vafd_pkg.
`timescale 1ns / 1ps

module vafd_norm_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  vafd_pkg::div_req_t  req,
    output logic                done,
    output logic [31:0]         result
);

    logic        busy_reg, busy_next;
    logic        fin_reg, fin_next;
    logic        done_reg;
    logic [2:0]  cnt_reg;
    logic [27:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] dn_reg;
    logic [7:0]  exp_reg;
    logic        sign_reg;
    logic [31:0] result_reg;

    logic [3:0]  lead;
    logic [15:0] mn;

    // leading one of the magnitude
    always_comb begin
        lead = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (req.mag[i]) lead = 4'(i);
        end
        mn = req.mag << (4'd15 - lead);
    end

    // four restoring steps
    always_comb begin
        logic [16:0] r;
        logic [27:0] q;
        r = r_reg;
        q = q_reg;
        for (int i = 0; i < 4; i++) begin
            if (r >= {1'b0, dn_reg}) begin
                r = r - {1'b0, dn_reg};
                q = {q[26:0], 1'b1};
            end else begin
                q = {q[26:0], 1'b0};
            end
            r = {r[15:0], 1'b0};
        end
        r_next = r;
        q_next = q;
    end

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        if (req.start) begin
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg == 3'd6) begin
            busy_next = 1'b0;
            fin_next  = 1'b1;
        end
    end

    // rounding and packing
    logic        hi;
    logic [23:0] mant;
    logic        guard, sticky, rnd;
    logic [24:0] sum;
    logic [7:0]  e1, e2;

    always_comb begin
        hi     = q_reg[27];
        mant   = hi ? q_reg[27:4] : q_reg[26:3];
        guard  = hi ? q_reg[3] : q_reg[2];
        sticky = (hi ? |q_reg[2:0] : |q_reg[1:0]) | (r_reg != 17'd0);
        rnd    = guard & (sticky | mant[0]);
        sum    = {1'b0, mant} + {24'd0, rnd};
        e1     = hi ? exp_reg : exp_reg - 8'd1;
        e2     = e1 + {7'd0, sum[24]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= fin_reg;
            if (req.start) cnt_reg <= 3'd0;
            else if (busy_reg) cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            r_reg    <= {1'b0, mn};
            q_reg    <= 28'd0;
            dn_reg   <= vafd_pkg::norm_divisor_top(req.kind);
            exp_reg  <= 8'd127 + {4'd0, lead} - {4'd0, vafd_pkg::norm_divisor_pos(req.kind)};
            sign_reg <= req.neg;
        end else if (busy_reg) begin
            r_reg <= r_next;
            q_reg <= q_next;
        end
        if (fin_reg) begin
            result_reg <= {sign_reg, e2, sum[24] ? 23'd0 : sum[22:0]};
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for vertex_attribute_fetch_decode_core.
// depends on vafd_pkg and the core; holds its own element decoder and a result queue.
`timescale 1ns / 1ps

module tb_top;
    import vafd_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        is_float;
        logic [3:0]  slot;
        logic [1:0]  status;
        logic        last;
    } comp_word_t;

    localparam int ITEM_BUDGET = 100;

    class fetch_scoreboard;
        logic [11:0] base;
        logic [7:0]  stride;
        logic [2:0]  ek;
        logic [2:0]  ck;
        bit          norm;
        bit          present;
        logic [12:0] blen;
        logic [7:0]  mem [BUFFER_BYTES];
        bit          written [BUFFER_BYTES];
        comp_word_t  pending_words [$];
        int          mismatches;

        function new();
            base = 0; stride = 0; ek = EK_SCALAR; ck = CK_FLOAT32;
            norm = 0; present = 1; blen = 0; mismatches = 0;
            foreach (written[i]) written[i] = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [12:0] v);
            case (idx)
                REG_BASE_OFFSET:  base = v[11:0];
                REG_STRIDE:       stride = v[7:0];
                REG_ELEMENT_KIND: ek = v[2:0];
                REG_COMP_KIND:    ck = v[2:0];
                REG_NORMALIZE:    norm = v[0];
                REG_PRESENT:      present = v[0];
                REG_LENGTH:       blen = v;
                default: ;
            endcase
        endfunction

        function logic [2:0] kind();
            return (ck > CK_FLOAT32) ? CK_FLOAT32 : ck;
        endfunction

        function int unsigned size_bytes();
            if (kind() <= CK_UINT8) return 1;
            if (kind() <= CK_UINT16) return 2;
            return 4;
        endfunction

        function int unsigned n_comps();
            case (ek)
                EK_SCALAR: return 1;
                EK_VEC2:   return 2;
                EK_VEC3:   return 3;
                EK_VEC4, EK_MAT2: return 4;
                EK_MAT3:   return 9;
                default:   return 16;
            endcase
        endfunction

        function int unsigned rows();
            case (ek)
                EK_MAT2: return 2;
                EK_MAT3: return 3;
                EK_MAT4, 3'd7: return 4;
                default: return 0;
            endcase
        endfunction

        function int unsigned pitch();
            return (rows() * size_bytes() + 3) & ~32'd3;
        endfunction

        function int unsigned slot_offset(int unsigned k);
            if (rows() == 0) return k * size_bytes();
            return (k / rows()) * pitch() + (k % rows()) * size_bytes();
        endfunction

        function int unsigned elem_stride();
            if (stride != 0) return stride;
            if (rows() == 0) return n_comps() * size_bytes();
            return rows() * pitch();
        endfunction

        function int unsigned limit();
            return (blen < BUFFER_BYTES) ? blen : BUFFER_BYTES;
        endfunction

        function int unsigned comp_addr(int unsigned elem, int unsigned k);
            return base + elem * elem_stride() + slot_offset(k);
        endfunction

        // single precision bits of a value in [-2, 2], round to nearest even
        function logic [31:0] to_single(real r);
            logic   sgn;
            int     e;
            real    m, frac, rem;
            longint t;
            if (r == 0.0) return 32'h0;
            sgn = (r < 0.0);
            m = sgn ? -r : r;
            e = 0;
            while (m < 1.0) begin
                m = m * 2.0;
                e--;
            end
            while (m >= 2.0) begin
                m = m / 2.0;
                e++;
            end
            frac = (m - 1.0) * 8388608.0;
            t = longint'($floor(frac));
            rem = frac - t;
            if (rem > 0.5 || (rem == 0.5 && t[0])) t++;
            if (t == 64'd8388608) begin
                t = 0;
                e++;
            end
            return {sgn, 8'(e + 127), t[22:0]};
        endfunction

        function comp_word_t decode(logic [31:0] raw, int unsigned k, bit is_last);
            comp_word_t w;
            int  s;
            real f;
            w = '{value: raw, is_float: 0, slot: 4'(k), status: ST_OK, last: is_last};
            case (kind())
                CK_INT8, CK_INT16: begin
                    s = (kind() == CK_INT8) ? int'($signed(raw[7:0])) : int'($signed(raw[15:0]));
                    if (norm) begin
                        f = s / ((kind() == CK_INT8) ? 127.0 : 32767.0);
                        if (f < -1.0) f = -1.0;
                        w.value = to_single(f);
                        w.is_float = 1;
                    end else begin
                        w.value = s;
                    end
                end
                CK_UINT8, CK_UINT16: begin
                    if (norm) begin
                        f = raw / ((kind() == CK_UINT8) ? 255.0 : 65535.0);
                        w.value = to_single(f);
                        w.is_float = 1;
                    end
                end
                CK_UINT32: ;
                default: w.is_float = 1;
            endcase
            return w;
        endfunction

        function void note_input(logic cmd, logic [11:0] addr, logic [7:0] data,
                                 logic [15:0] elem);
            comp_word_t  words [$];
            comp_word_t  w;
            int unsigned a, sz;
            logic [31:0] raw;
            if (cmd == CMD_WRITE) begin
                mem[addr] = data;
                written[addr] = 1;
                return;
            end
            sz = size_bytes();
            for (int unsigned k = 0; k < n_comps(); k++) begin
                if (!present) begin
                    w = '{value: 0,
                        is_float: (kind() == CK_FLOAT32 || (norm && kind() <= CK_UINT16)),
                        slot: 4'(k), status: ST_OK, last: (k + 1 == n_comps())};
                    words = {words, w};
                    continue;
                end
                a = comp_addr(elem, k);
                if (a + sz > limit()) begin
                    w = '{0, 1'b0, 4'(k), ST_RANGE, 1'b1};
                    pending_words = {pending_words, w};
                    return;
                end
                if (norm && kind() >= CK_UINT32) begin
                    w = '{0, 1'b0, 4'(k), ST_NORM_ERROR, 1'b1};
                    pending_words = {pending_words, w};
                    return;
                end
                raw = 0;
                for (int unsigned b = 0; b < sz; b++) raw[8*b +: 8] = mem[a + b];
                words = {words, decode(raw, k, k + 1 == n_comps())};
            end
            pending_words = {pending_words, words};
        endfunction

        function void check_result(comp_word_t got);
            comp_word_t want;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", got);
                return;
            end
            want = pending_words.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value %h float %b slot %0d status %0d last %b,",
                             want.value, want.is_float, want.slot, want.status, want.last,
                             " got value %h float %b slot %0d status %0d last %b",
                             got.value, got.is_float, got.slot, got.status, got.last);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 0;
    logic [2:0]  cfg_addr = '0;
    logic [12:0] cfg_wdata = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_sent = 0;

    fetch_scoreboard sb = new();

    always #5 aclk = ~aclk;

    vertex_attribute_fetch_decode_core dut (.*);

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{m_tdata[31:0], m_tuser, m_tdata[35:32], m_tdata[37:36], m_tlast});

    // present one word and hold it until taken; caller keeps time moving at the same step
    task automatic send_word(logic cmd, logic [11:0] addr, logic [7:0] data, logic [15:0] elem);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, elem, data, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, addr, data, elem);
        n_sent++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'h80;
            2: return 8'h7F;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_element();
        int unsigned span, maxi;
        span = sb.slot_offset(sb.n_comps() - 1) + sb.size_bytes();
        if (sb.base + span > sb.limit() || $urandom_range(9) >= 8)
            return 16'($urandom);
        maxi = (sb.limit() - sb.base - span) / sb.elem_stride();
        if (maxi > 65534) maxi = 65534;
        if ($urandom_range(9) == 0) return 16'(maxi + 1);
        return 16'($urandom_range(0, maxi));
    endfunction

    // write every in-range byte the fetch would read that holds no data yet (all of them on refresh), then fetch
    task automatic fetch_element(logic [15:0] elem, bit refresh);
        int unsigned a;
        if (sb.present) begin
            for (int unsigned k = 0; k < sb.n_comps(); k++) begin
                a = sb.comp_addr(elem, k);
                if (a + sb.size_bytes() > sb.limit()) break;
                for (int unsigned b = 0; b < sb.size_bytes(); b++)
                    if (!sb.written[a + b] || refresh)
                        send_word(CMD_WRITE, 12'(a + b), pick_byte(), 16'($urandom));
            end
        end
        send_word(CMD_FETCH, 12'($urandom), 8'($urandom), elem);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_words.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_config(logic [12:0] vals [7]);
        for (int i = 0; i < 7; i++) begin
            cfg_wr_en <= 1;
            cfg_addr  <= 3'(i);
            cfg_wdata <= vals[i];
            sb.set_reg(cfg_reg_t'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 0;
    endtask

    task automatic run_phase(logic [12:0] vals [7], int n_fetch, int mode, bit directed);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
        write_config(vals);
        for (int i = 0; i < n_fetch && n_sent < ITEM_BUDGET; i++) begin
            if (!directed && $urandom_range(4) == 0)
                send_word(CMD_WRITE, 12'($urandom), 8'($urandom), 16'($urandom));
            fetch_element((directed && i == 0) ? 16'd0 : pick_element(),
                          !directed && $urandom_range(7) == 0);
        end
        drain();
    endtask

    logic [12:0] plan [9][7] = '{
        '{0,    0,   EK_SCALAR, CK_INT8,    1, 1, 4096},  // int8 -128 clamps to -1
        '{2,    0,   EK_VEC2,   CK_INT16,   1, 1, 4096},  // int16 -32768 clamps
        '{0,    0,   EK_MAT3,   CK_UINT8,   1, 1, 4096},  // column padding
        '{4095, 255, EK_MAT2,   CK_UINT16,  0, 1, 4096},  // runs off the end
        '{0,    0,   3'd7,      CK_UINT8,   0, 1, 4096},  // unused element kind
        '{0,    0,   EK_VEC3,   CK_UINT32,  1, 1, 4096},  // illegal normalize
        '{0,    0,   EK_MAT4,   3'd7,       0, 0, 0},     // no buffer, unused component kind
        '{16,   0,   EK_VEC4,   CK_INT8,    0, 1, 0},     // zero length
        '{0,    0,   EK_MAT3,   CK_INT16,   0, 1, 8191}
    };

    initial begin
        logic [12:0] vals [7];
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_word(CMD_WRITE, 12'd0, 8'h80, 16'hFFFF);
        send_word(CMD_WRITE, 12'd2, 8'h00, 16'h0000);
        send_word(CMD_WRITE, 12'd3, 8'h80, 16'h0000);
        send_word(CMD_WRITE, 12'hFFF, 8'h5A, 16'h0000);
        drain();
        for (int p = 0; p < 9; p++) run_phase(plan[p], 1, p, 1);
        for (int p = 0; p < 10; p++) begin
            vals[REG_BASE_OFFSET]  = ($urandom_range(1) != 0) ? $urandom_range(0, 512)
                                   : $urandom_range(0, 4095);
            vals[REG_STRIDE]       = ($urandom_range(2) == 0) ? 0 : $urandom_range(0, 255);
            vals[REG_ELEMENT_KIND] = $urandom_range(0, 7);
            vals[REG_COMP_KIND]    = $urandom_range(0, 7);
            vals[REG_NORMALIZE]    = ($urandom_range(3) == 0);
            vals[REG_PRESENT]      = ($urandom_range(6) != 0);
            case ($urandom_range(4))
                0: vals[REG_LENGTH] = $urandom_range(0, 4096);
                1: vals[REG_LENGTH] = $urandom_range(0, 8191);
                default: vals[REG_LENGTH] = 4096;
            endcase
            run_phase(vals, 9, p, 0);
        end
        if (sb.mismatches == 0 && sb.pending_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
